// File: hdl/video_test_pattern_generator_core_macros.svh
`ifndef VIDEO_TEST_PATTERN_GENERATOR_CORE_MACROS_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define VTPG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define VTPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/vtpg_pkg.sv
package vtpg_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

    localparam logic [1:0] FMT_RGB24 = 2'd0;
    localparam logic [1:0] FMT_MONO8 = 2'd1;
    localparam logic [1:0] FMT_GBRG8 = 2'd2;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int BAR_STEP = 7;
    localparam int BAR_DIV  = 80;
    localparam int BAR_MIN  = 2;

    localparam int FRAME_W    = 64;
    localparam int SWEEP_BITS = FRAME_W + 3;
    localparam int POS_W      = 12;
    localparam int PHASE_W    = 8;

    typedef struct packed {
        logic [7:0]         byte0;
        logic [7:0]         byte1;
        logic [7:0]         byte2;
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   line;
        logic               eol;
        logic               eof;
        logic [PHASE_W-1:0] phase;
    } pixel_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sweep_t;

endpackage

// File: hdl/video_test_pattern_generator_core.sv
// Raster test pattern source: every accepted request yields one pixel of the
// moving pattern, so a pixel can be taken every clock cycle while req_stall is
// low, and each pixel is registered in the output buffer; a two-entry output
// buffer lets one more request in while a pixel waits. After a write to
// frame_width the bar position (frame*7 mod width) is rebuilt one bit per
// cycle from the 64-bit frame number; requests are stalled until it is done.
// Writes to the other registers take effect at once.
`include "video_test_pattern_generator_core_macros.svh"

module video_test_pattern_generator_core
    import vtpg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic                   restart,
    output logic                   pix_valid,
    input  logic                   pix_stall,
    output logic [7:0]             pixel_byte0,
    output logic [7:0]             pixel_byte1,
    output logic [7:0]             pixel_byte2,
    output logic [POS_W-1:0]       column,
    output logic [POS_W-1:0]       line,
    output logic                   end_of_line,
    output logic                   end_of_frame,
    output logic [PHASE_W-1:0]     frame_phase,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_WIDTH);

    logic [WW-1:0]      eff_width;
    logic [HW-1:0]      eff_height;
    logic [1:0]         format;
    logic [WW-1:0]      bar_span;
    logic [WW-1:0]      bar_half;
    logic [2:0]         step;
    logic [RW-1:0]      sweep_residue;
    logic [RW-1:0]      residue;
    logic [FRAME_W-1:0] frame;
    sweep_t             sweep;
    pixel_t             result;
    pixel_t             dout;
    logic               skid_full;
    logic               accept;

    assign req_stall = sweep.busy || skid_full;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    vtpg_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .frame      (frame),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .format     (format),
        .bar_span   (bar_span),
        .bar_half   (bar_half),
        .step       (step),
        .residue    (sweep_residue),
        .sweep      (sweep)
    );

    vtpg_pixel #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pixel (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .restart       (restart),
        .eff_width     (eff_width),
        .eff_height    (eff_height),
        .format        (format),
        .bar_span      (bar_span),
        .bar_half      (bar_half),
        .step          (step),
        .sweep         (sweep),
        .sweep_residue (sweep_residue),
        .result        (result),
        .frame         (frame),
        .residue       (residue)
    );

    vtpg_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (result),
        .full      (skid_full),
        .out_valid (pix_valid),
        .out_stall (pix_stall),
        .dout      (dout)
    );

    assign pixel_byte0  = dout.byte0;
    assign pixel_byte1  = dout.byte1;
    assign pixel_byte2  = dout.byte2;
    assign column       = dout.column;
    assign line         = dout.line;
    assign end_of_line  = dout.eol;
    assign end_of_frame = dout.eof;
    assign frame_phase  = dout.phase;

    `VTPG_ASSERT_IMPLIES(a_skid_behind_head, skid_full, pix_valid, "skid item without head item")
    `VTPG_ASSERT_IMPLIES(a_residue_range, !sweep.busy, WW'(residue) < eff_width, "bad residue")
    `VTPG_ASSERT_IMPLIES(a_eof_has_eol, pix_valid && end_of_frame, end_of_line, "eof off eol")
    `VTPG_ASSERT_NEXT(a_sweep_ends, sweep.done, !sweep.busy, "residue sweep still busy after done")

endmodule

// File: hdl/vtpg_cfg.sv
module vtpg_cfg
    import vtpg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int RW = $clog2(MAX_WIDTH)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [FRAME_W-1:0]     frame,
    output logic [WW-1:0]          eff_width,
    output logic [HW-1:0]          eff_height,
    output logic [1:0]             format,
    output logic [WW-1:0]          bar_span,
    output logic [WW-1:0]          bar_half,
    output logic [2:0]             step,
    output logic [RW-1:0]          residue,
    output sweep_t                 sweep
);

    localparam int RST_W  = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;
    localparam int RST_BW = (RST_W / BAR_DIV < BAR_MIN) ? BAR_MIN : RST_W / BAR_DIV;
    localparam int RST_K  = BAR_STEP % RST_W;
    // w/80 = (w/16)/5, /5 by reciprocal 3277/2^14, exact below 5461
    localparam int DIV_MUL   = 3277;
    localparam int DIV_SHIFT = 14;
    localparam int PW        = WW + 12;
    localparam int CNT_W     = $clog2(SWEEP_BITS);
    localparam int TW        = RW + 2;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [1:0]            format_reg;
    logic [WW-1:0]         bw_reg;
    logic [WW-1:0]         half_reg;
    logic [2:0]            step_reg;

    logic [WW-1:0]         quot16;
    logic [PW-1:0]         prod;
    logic [WW-1:0]         bw_raw;
    logic [WW-1:0]         bw_next;
    logic [2:0]            step_next;

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SWEEP_BITS-1:0] sh_reg;
    logic [RW-1:0]         rem_reg;
    logic [RW-1:0]         rem_next;
    logic [TW-1:0]         trial;
    logic                  load;
    logic                  last;

    function automatic logic [2:0] seven_mod(input logic [2:0] w);
        logic [2:0] r;
        unique case (w)
            3'd1:    r = 3'd0;
            3'd2:    r = 3'd1;
            3'd3:    r = 3'd1;
            3'd4:    r = 3'd3;
            3'd5:    r = 3'd2;
            3'd6:    r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_DATA_W'(RESET_WIDTH);
            height_reg <= CFG_DATA_W'(RESET_HEIGHT);
            format_reg <= FMT_RGB24;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                REG_PIXEL_FORMAT: format_reg <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg == '0)
            eff_width = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_width = WW'(MAX_WIDTH);
        else
            eff_width = WW'(width_reg);

        priority if (height_reg == '0)
            eff_height = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            eff_height = HW'(MAX_HEIGHT);
        else
            eff_height = HW'(height_reg);
    end

    always_comb
    begin
        quot16  = eff_width >> 4;
        prod    = PW'(quot16) * PW'(DIV_MUL);
        bw_raw  = WW'(prod >> DIV_SHIFT);
        bw_next = (bw_raw < WW'(BAR_MIN)) ? WW'(BAR_MIN) : bw_raw;
        if (eff_width > WW'(BAR_STEP))
            step_next = 3'(BAR_STEP);
        else
            step_next = seven_mod(eff_width[2:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg   <= WW'(RST_BW);
            half_reg <= WW'(RST_BW / 2);
            step_reg <= 3'(RST_K);
        end
        else
        begin
            bw_reg   <= bw_next;
            half_reg <= bw_next >> 1;
            step_reg <= step_next;
        end
    end

    // bit-serial (frame*7) mod width, MSB first
    assign load  = cfg_valid && (cfg_index == REG_FRAME_WIDTH);
    assign last  = (cnt_reg == CNT_W'(SWEEP_BITS - 1));
    assign trial = {1'b0, rem_reg, sh_reg[SWEEP_BITS-1]};

    always_comb
    begin
        if (trial >= TW'(eff_width))
            rem_next = RW'(trial - TW'(eff_width));
        else
            rem_next = RW'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (last)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sh_reg  <= {frame, 3'b000} - {3'b000, frame};
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign format     = format_reg;
    assign bar_span   = bw_reg;
    assign bar_half   = half_reg;
    assign step       = step_reg;
    assign residue    = rem_next;
    assign sweep.busy = busy_reg;
    assign sweep.done = busy_reg && last && !load;

endmodule

// File: hdl/vtpg_pixel.sv
module vtpg_pixel
    import vtpg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int RW = $clog2(MAX_WIDTH),
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int LW = $clog2(MAX_HEIGHT)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               restart,
    input  logic [WW-1:0]      eff_width,
    input  logic [HW-1:0]      eff_height,
    input  logic [1:0]         format,
    input  logic [WW-1:0]      bar_span,
    input  logic [WW-1:0]      bar_half,
    input  logic [2:0]         step,
    input  sweep_t             sweep,
    input  logic [RW-1:0]      sweep_residue,
    output pixel_t             result,
    output logic [FRAME_W-1:0] frame,
    output logic [RW-1:0]      residue
);

    localparam int RST_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;

    logic [CW-1:0]      col_reg;
    logic [LW-1:0]      line_reg;
    logic [LW-1:0]      third_reg;
    logic [1:0]         rest_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [RW-1:0]      res_reg;
    logic [RW-1:0]      bs_reg;
    logic [WW-1:0]      be_reg;

    logic [CW-1:0]      x_e;
    logic [LW-1:0]      y_e;
    logic [LW-1:0]      t_e;
    logic [1:0]         r_e;
    logic [RW-1:0]      res_e;
    logic [7:0]         p;
    logic [7:0]         p2;
    logic [7:0]         p3;
    logic [7:0]         p5;
    logic [8:0]         x9;
    logic [8:0]         y9;
    logic [7:0]         t8;
    logic [7:0]         xh;
    logic [7:0]         yh;
    logic [7:0]         cr;
    logic [7:0]         cg;
    logic [7:0]         cb;
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic               first;
    logic               in_bar;
    logic [RW-1:0]      bs_c;
    logic [WW:0]        be_sum;
    logic [WW-1:0]      be_c;
    logic               eol;
    logic               eof;
    logic [1:0]         inc;

    function automatic logic [RW-1:0] step_res(
        input logic [RW-1:0] r,
        input logic [2:0]    k,
        input logic [WW-1:0] w
    );
        logic [WW:0] s;
        s = (WW+1)'(r) + (WW+1)'(k);
        if (s >= (WW+1)'(w))
            s = s - (WW+1)'(w);
        return RW'(s);
    endfunction

    always_comb
    begin
        x_e   = restart ? '0 : col_reg;
        y_e   = restart ? '0 : line_reg;
        t_e   = restart ? '0 : third_reg;
        r_e   = restart ? '0 : rest_reg;
        res_e = restart ? step_res(res_reg, step, eff_width) : res_reg;
        p     = frame_reg[7:0] + 8'(restart);
        p2    = p << 1;
        p3    = p2 + p;
        p5    = (p << 2) + p;
        x9    = 9'(x_e);
        y9    = 9'(y_e);
        t8    = 8'(t_e);
        xh    = x9[8:1];
        yh    = y9[8:1];
        first = (x_e == '0) && (y_e == '0);

        if (WW'(res_e) >= bar_half)
            bs_c = RW'(WW'(res_e) - bar_half);
        else
            bs_c = '0;
        be_sum = (WW+1)'(bs_c) + (WW+1)'(bar_span);
        be_c   = (be_sum > (WW+1)'(eff_width)) ? eff_width : WW'(be_sum);

        // on the first pixel the bar is fresh: column 0 is covered iff start is 0
        if (first)
            in_bar = (WW'(res_e) <= bar_half);
        else
            in_bar = (WW'(x_e) >= WW'(bs_reg)) && (WW'(x_e) < be_reg);

        eol = ((WW'(x_e) + WW'(1)) >= eff_width);
        eof = eol && ((HW'(y_e) + HW'(1)) >= eff_height);

        cr = x9[7:0] + p2;
        cg = y9[7:0] + p3;
        cb = xh + yh + p5;
        b1 = 8'h00;
        b2 = 8'h00;
        unique case (format)
            FMT_RGB24:
            begin
                b0 = x9[7:0] + p;
                b1 = y9[7:0] + p2;
                b2 = xh + yh + p3;
            end
            FMT_GBRG8:
            begin
                if (y9[0])
                    b0 = x9[0] ? cg : cr;
                else
                    b0 = x9[0] ? cb : cg;
            end
            default:
                b0 = xh + t8 + p3;
        endcase

        if (in_bar)
        begin
            b0 = 8'hff;
            if (format == FMT_RGB24)
            begin
                b1 = 8'hff;
                b2 = 8'hff;
            end
        end

        inc = {1'b0, restart} + {1'b0, eof};
    end

    assign result.byte0  = b0;
    assign result.byte1  = b1;
    assign result.byte2  = b2;
    assign result.column = POS_W'(x_e);
    assign result.line   = POS_W'(y_e);
    assign result.eol    = eol;
    assign result.eof    = eof;
    assign result.phase  = p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            line_reg  <= '0;
            third_reg <= '0;
            rest_reg  <= '0;
            frame_reg <= FRAME_W'(1);
            res_reg   <= RW'(BAR_STEP % RST_W);
        end
        else if (sweep.done)
        begin
            res_reg <= sweep_residue;
        end
        else if (accept)
        begin
            frame_reg <= frame_reg + FRAME_W'(inc);
            res_reg   <= eof ? step_res(res_e, step, eff_width) : res_e;
            if (eof)
            begin
                col_reg   <= '0;
                line_reg  <= '0;
                third_reg <= '0;
                rest_reg  <= '0;
            end
            else if (eol)
            begin
                col_reg  <= '0;
                line_reg <= y_e + LW'(1);
                if (r_e == 2'd2)
                begin
                    rest_reg  <= '0;
                    third_reg <= t_e + LW'(1);
                end
                else
                begin
                    rest_reg  <= r_e + 2'd1;
                    third_reg <= t_e;
                end
            end
            else
            begin
                col_reg   <= x_e + CW'(1);
                line_reg  <= y_e;
                third_reg <= t_e;
                rest_reg  <= r_e;
            end
        end
    end

    // bar geometry latched on the first pixel of each frame
    always_ff @(posedge clk)
    begin
        if (accept && first)
        begin
            bs_reg <= bs_c;
            be_reg <= be_c;
        end
    end

    assign frame   = frame_reg;
    assign residue = res_reg;

endmodule

// File: hdl/vtpg_skid.sv
module vtpg_skid
    import vtpg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  pixel_t din,
    output logic   full,
    output logic   out_valid,
    input  logic   out_stall,
    output pixel_t dout
);

    logic   main_v_reg;
    logic   skid_v_reg;
    pixel_t main_reg;
    pixel_t skid_reg;
    logic   take;
    logic   main_free;

    assign take      = main_v_reg && !out_stall;
    assign main_free = !main_v_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_v_reg <= skid_v_reg || push;
            skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
            main_reg <= skid_v_reg ? skid_reg : din;
        else if (push)
            skid_reg <= din;
    end

    assign full      = skid_v_reg;
    assign out_valid = main_v_reg;
    assign dout      = main_reg;

endmodule
